@@ hw/rtl/fixed_block_free_list_allocator_unit_macros.svh @@
// Assertion macros for the free list allocator RTL.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define FBFL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define FBFL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/fbfl_pkg.sv @@
// Package with the types and constants of the free list allocator.
package fbfl_pkg;

	localparam int MAX_BLOCKS   = 1024;
	localparam int HEADER_BYTES = 64;
	localparam int ADDR_W       = 32;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int DIV_W        = ADDR_W + 1;
	localparam int FIRST_W      = ADDR_W + 2;
	localparam int ALIGN_W      = 4;
	localparam int REG_IDX_W    = 2;
	localparam int FREE_COUNT_W = 11;

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_INIT  = 2'd2,
		KIND_NOP   = 2'd3
	} fbfl_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD_GEOM = 2'd2,
		ST_IGNORED  = 2'd3
	} fbfl_status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BASE_ADDRESS   = 2'd0,
		REG_REGION_SIZE    = 2'd1,
		REG_BLOCK_SIZE     = 2'd2,
		REG_ALIGNMENT_LOG2 = 2'd3
	} fbfl_reg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] free_address;
	} fbfl_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0]       block_address;
		logic [1:0]              status;
		logic [FREE_COUNT_W-1:0] free_count;
	} fbfl_out_t;

endpackage

@@ hw/rtl/fbfl_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module fbfl_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [fbfl_pkg::DIV_W-1:0] dividend,
	input  logic [fbfl_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [fbfl_pkg::DIV_W-1:0] quotient
);
	import fbfl_pkg::*;

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic [STEP_W-1:0] steps_q;
	logic              done_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = !diff[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			done_q  <= 1'b0;
		end else if (start) begin
			steps_q <= STEP_W'(DIV_W);
			done_q  <= 1'b0;
		end else if (steps_q != '0) begin
			steps_q <= steps_q - STEP_W'(1);
			done_q  <= (steps_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (steps_q != '0) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hw/rtl/fixed_block_free_list_allocator_unit.sv @@
// Top level of the fixed-size block pool allocator with a LIFO free list.
//
//   channel   direction   handshake            payload
//   in        to block    in_valid / in_stall  fbfl_in_t   (kind, free_address)
//   out       from block  out_valid / out_stall fbfl_out_t (block_address, status, free_count)
//   cfg       to block    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item is in work at a time; each gives one result through an output register.
// Initialize and free wait on the 33-step shared divider.
// Allocate steps through the link memory read, when a freed block is reused, then the address multiply and add.
// The link memory is not cleared after reset; only entries already pushed are read.
// A full output register holds the finished result until out_stall is low.
module fixed_block_free_list_allocator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  fbfl_pkg::fbfl_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output fbfl_pkg::fbfl_out_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fbfl_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [fbfl_pkg::ADDR_W-1:0]         cfg_data
);
	import fbfl_pkg::*;

	`include "fixed_block_free_list_allocator_unit_macros.svh"

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT_A,
		S_INIT_B,
		S_INIT_C,
		S_INIT_DIV,
		S_FREE_CHK,
		S_FREE_DIV,
		S_ALLOC_RD,
		S_ALLOC_MUL,
		S_ALLOC_ADD,
		S_FINISH
	} state_t;

	localparam logic [DIV_W-1:0] ADDR_LIMIT = {1'b1, {ADDR_W{1'b0}}};
	localparam logic [DIV_W-1:0] WORD_MASK  = DIV_W'(3);

	state_t state_q;

	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  size_q;
	logic [ADDR_W-1:0]  bsize_q;
	logic [ALIGN_W-1:0] align_q;

	logic [CNT_W-1:0]  freed_head_q;
	logic [CNT_W-1:0]  untouched_q;
	logic [CNT_W-1:0]  free_blocks_q;
	logic [CNT_W-1:0]  total_blocks_q;
	logic [ADDR_W-1:0] data_start_q;
	logic [ADDR_W-1:0] aligned_q;
	logic              heap_ready_q;

	logic [ADDR_W-1:0]  addr_q;
	logic [DIV_W-1:0]   start_q;
	logic [DIV_W-1:0]   end_q;
	logic [DIV_W-1:0]   bsz_q;
	logic [FIRST_W-1:0] first_q;
	logic               bad_q;
	logic [CNT_W-1:0]   idx_q;
	logic [ADDR_W-1:0]  prod_q;
	logic [ADDR_W-1:0]  res_addr_q;
	fbfl_status_t       res_status_q;
	logic               out_valid_q;
	fbfl_out_t          out_data_q;

	logic [CNT_W-1:0] link_mem [MAX_BLOCKS];
	logic [CNT_W-1:0] link_rd_q;
	logic             link_we;
	logic [IDX_W-1:0] link_wr_idx;

	logic [DIV_W-1:0]          align_mask;
	logic [DIV_W-1:0]          sum_raw;
	logic [DIV_W-1:0]          end_raw;
	logic [FIRST_W-1:0]        span;
	logic                      init_bad;
	logic                      free_ign;
	logic                      free_ok;
	logic                      div_start;
	logic [DIV_W-1:0]          div_dividend;
	logic [DIV_W-1:0]          div_divisor;
	logic                      div_done;
	logic [DIV_W-1:0]          div_quo;
	logic [CNT_W+ADDR_W-1:0]   prod_full;
	logic                      in_xfer;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign align_mask = (DIV_W'(1) << align_q) - DIV_W'(1);
	assign sum_raw    = DIV_W'(base_q) + DIV_W'(size_q);
	assign end_raw    = sum_raw & ~WORD_MASK;
	assign span       = FIRST_W'(end_q) - first_q;
	assign prod_full  = idx_q * aligned_q;

	always_comb begin
		init_bad = bad_q || (first_q >= FIRST_W'(end_q)) || (bsz_q == '0);
		free_ign = (addr_q == '0) || !heap_ready_q || (addr_q < data_start_q)
			|| (aligned_q == '0);
		free_ok  = (div_quo < DIV_W'(total_blocks_q)) && (free_blocks_q < total_blocks_q);
		div_start    = 1'b0;
		div_dividend = DIV_W'(addr_q - data_start_q);
		div_divisor  = DIV_W'(aligned_q);
		case (state_q)
			S_INIT_C: begin
				div_start    = !init_bad;
				div_dividend = span[DIV_W-1:0];
				div_divisor  = bsz_q;
			end
			S_FREE_CHK: begin
				div_start = !free_ign;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
		link_we     = (state_q == S_FREE_DIV) && div_done && free_ok;
		link_wr_idx = div_quo[IDX_W-1:0];
	end

	fbfl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wr_idx] <= freed_head_q;
		end
		link_rd_q <= link_mem[freed_head_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			size_q  <= '0;
			bsize_q <= ADDR_W'(4);
			align_q <= ALIGN_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			case (fbfl_reg_t'(cfg_index))
				REG_BASE_ADDRESS:   base_q  <= cfg_data;
				REG_REGION_SIZE:    size_q  <= cfg_data;
				REG_BLOCK_SIZE:     bsize_q <= cfg_data;
				REG_ALIGNMENT_LOG2: align_q <= cfg_data[ALIGN_W-1:0];
				default:            base_q  <= base_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			freed_head_q   <= CNT_W'(MAX_BLOCKS);
			untouched_q    <= '0;
			free_blocks_q  <= '0;
			total_blocks_q <= '0;
			data_start_q   <= '0;
			aligned_q      <= '0;
			heap_ready_q   <= 1'b0;
			addr_q         <= '0;
			start_q        <= '0;
			end_q          <= '0;
			bsz_q          <= '0;
			first_q        <= '0;
			bad_q          <= 1'b0;
			idx_q          <= '0;
			prod_q         <= '0;
			res_addr_q     <= '0;
			res_status_q   <= ST_OK;
			out_valid_q    <= 1'b0;
			out_data_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						addr_q     <= in_data.free_address;
						res_addr_q <= '0;
						case (fbfl_kind_t'(in_data.kind))
							KIND_ALLOC: begin
								if (!heap_ready_q || free_blocks_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_FINISH;
								end else if (freed_head_q < CNT_W'(MAX_BLOCKS)) begin
									idx_q   <= freed_head_q;
									state_q <= S_ALLOC_RD;
								end else if (untouched_q < total_blocks_q) begin
									idx_q       <= untouched_q;
									untouched_q <= untouched_q + CNT_W'(1);
									state_q     <= S_ALLOC_MUL;
								end else begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_FINISH;
								end
							end
							KIND_FREE: begin
								state_q <= S_FREE_CHK;
							end
							KIND_INIT: begin
								state_q <= S_INIT_A;
							end
							default: begin
								res_status_q <= ST_IGNORED;
								state_q      <= S_FINISH;
							end
						endcase
					end
				end
				S_INIT_A: begin
					freed_head_q   <= CNT_W'(MAX_BLOCKS);
					untouched_q    <= '0;
					free_blocks_q  <= '0;
					total_blocks_q <= '0;
					data_start_q   <= '0;
					aligned_q      <= '0;
					heap_ready_q   <= 1'b0;
					start_q        <= (DIV_W'(base_q) + WORD_MASK) & ~WORD_MASK;
					end_q          <= (end_raw > ADDR_LIMIT) ? ADDR_LIMIT : end_raw;
					bsz_q          <= (DIV_W'(bsize_q) + align_mask) & ~align_mask;
					state_q        <= S_INIT_B;
				end
				S_INIT_B: begin
					first_q <= (FIRST_W'(start_q) + FIRST_W'(HEADER_BYTES)
						+ FIRST_W'(align_mask)) & ~FIRST_W'(align_mask);
					bad_q   <= (start_q >= end_q);
					state_q <= S_INIT_C;
				end
				S_INIT_C: begin
					if (init_bad) begin
						res_status_q <= ST_BAD_GEOM;
						state_q      <= S_FINISH;
					end else begin
						state_q <= S_INIT_DIV;
					end
				end
				S_INIT_DIV: begin
					if (div_done) begin
						if (div_quo == '0) begin
							res_status_q <= ST_BAD_GEOM;
						end else begin
							if (div_quo > DIV_W'(MAX_BLOCKS)) begin
								total_blocks_q <= CNT_W'(MAX_BLOCKS);
								free_blocks_q  <= CNT_W'(MAX_BLOCKS);
							end else begin
								total_blocks_q <= div_quo[CNT_W-1:0];
								free_blocks_q  <= div_quo[CNT_W-1:0];
							end
							data_start_q <= first_q[ADDR_W-1:0];
							aligned_q    <= bsz_q[ADDR_W-1:0];
							heap_ready_q <= 1'b1;
							res_status_q <= ST_OK;
						end
						state_q <= S_FINISH;
					end
				end
				S_FREE_CHK: begin
					if (free_ign) begin
						res_status_q <= ST_IGNORED;
						state_q      <= S_FINISH;
					end else begin
						state_q <= S_FREE_DIV;
					end
				end
				S_FREE_DIV: begin
					if (div_done) begin
						if (free_ok) begin
							freed_head_q  <= CNT_W'(link_wr_idx);
							free_blocks_q <= free_blocks_q + CNT_W'(1);
							res_status_q  <= ST_OK;
						end else begin
							res_status_q <= ST_IGNORED;
						end
						state_q <= S_FINISH;
					end
				end
				S_ALLOC_RD: begin
					freed_head_q <= link_rd_q;
					state_q      <= S_ALLOC_MUL;
				end
				S_ALLOC_MUL: begin
					prod_q        <= prod_full[ADDR_W-1:0];
					free_blocks_q <= free_blocks_q - CNT_W'(1);
					state_q       <= S_ALLOC_ADD;
				end
				S_ALLOC_ADD: begin
					res_addr_q   <= data_start_q + prod_q;
					res_status_q <= ST_OK;
					state_q      <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_data_q.block_address <= res_addr_q;
						out_data_q.status        <= res_status_q;
						out_data_q.free_count    <= FREE_COUNT_W'(free_blocks_q);
						out_valid_q              <= 1'b1;
						state_q                  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FBFL_ASSERT_IMPL(a_free_le_total, 1'b1, free_blocks_q <= total_blocks_q, "free count exceeds block count")
	`FBFL_ASSERT_IMPL(a_idle_heap_empty, !heap_ready_q, free_blocks_q == '0, "free blocks without a heap")
	`FBFL_ASSERT_IMPL(a_div_done_waiting, div_done, state_q == S_INIT_DIV || state_q == S_FREE_DIV, "divider finished with no waiting item")
	`FBFL_ASSERT_NEXT(a_push_head, link_we, freed_head_q == CNT_W'($past(link_wr_idx)), "pushed block is not the new head")

endmodule
